// ===== rtl/core/iqma_pkg.sv =====
// Package for the IQ moment accumulator: payload structs, sizes and
// single-precision multiply and add functions. No dependencies.
package iqma_pkg;

    localparam int unsigned CHUNK = 256;
    localparam int unsigned CNT_W = $clog2(CHUNK + 1);
    localparam logic [31:0] QNAN = 32'h7FC0_0000;
    localparam logic [31:0] POS_ZERO = 32'h0000_0000;

    typedef struct packed {
        logic [31:0] sample_i;
        logic [31:0] sample_q;
        logic        block_end;
    } iqma_in_t;

    typedef struct packed {
        logic [31:0] sum_i;
        logic [31:0] sum_q;
        logic [31:0] sum_ii;
        logic [31:0] sum_qq;
        logic [31:0] sum_iq;
        logic        chunk_last;
    } iqma_out_t;

    // Flush a denormal operand to a zero of its sign.
    function automatic logic [31:0] daz(input logic [31:0] x);
        daz = (x[30:23] == 8'd0) ? {x[31], 31'd0} : x;
    endfunction

    function automatic logic is_nan(input logic [31:0] x);
        is_nan = (x[30:0] > 31'h7F80_0000);
    endfunction

    function automatic logic is_inf(input logic [31:0] x);
        is_inf = (x[30:0] == 31'h7F80_0000);
    endfunction

    function automatic logic is_zero(input logic [31:0] x);
        is_zero = (x[30:0] == 31'd0);
    endfunction

    // Round a 48-bit significand whose leading one sits in bit 47 or 46.
    // The value is sig * 2^(e - 127 - 47); e is the biased exponent
    // when the leading one is in bit 47.
    function automatic logic [31:0] round_mul(input logic sign, input logic [10:0] e_in,
                                               input logic [47:0] sig_in);
        logic [47:0] sig;
        logic signed [10:0] e;
        logic [24:0] m;
        logic        rnd;
        sig = sig_in;
        e = e_in;
        if (!sig[47]) begin
            sig = sig << 1;
            e = e - 11'sd1;
        end
        rnd = sig[23] && ((sig[22:0] != 23'd0) || sig[24]);
        m = {1'b0, sig[47:24]} + {24'd0, rnd};
        if (m[24]) begin
            m = m >> 1;
            e = e + 11'sd1;
        end
        if (e >= 11'sd255) begin
            round_mul = {sign, 8'hFF, 23'd0};
        end else if (e <= 11'sd0) begin
            round_mul = {sign, 31'd0};
        end else begin
            round_mul = {sign, e[7:0], m[22:0]};
        end
    endfunction

    // Single-precision multiply with flush-to-zero and RNE.
    function automatic logic [31:0] fmul(input logic [31:0] a_in, input logic [31:0] b_in);
        logic [31:0] a;
        logic [31:0] b;
        logic        sign;
        logic [10:0] e;
        logic [47:0] p;
        a = daz(a_in);
        b = daz(b_in);
        sign = a[31] ^ b[31];
        p = {1'b1, a[22:0]} * {1'b1, b[22:0]};
        // Exponent of the product with leading one in bit 47.
        e = {3'd0, a[30:23]} + {3'd0, b[30:23]} - 11'd126;
        if (is_nan(a) || is_nan(b)) begin
            fmul = QNAN;
        end else if (is_inf(a) || is_inf(b)) begin
            fmul = (is_zero(a) || is_zero(b)) ? QNAN : {sign, 8'hFF, 23'd0};
        end else if (is_zero(a) || is_zero(b)) begin
            fmul = {sign, 31'd0};
        end else begin
            fmul = round_mul(sign, e, p);
        end
    endfunction

    // Count leading zeros of a 28-bit word.
    function automatic logic [4:0] clz28(input logic [27:0] x);
        logic [4:0] n;
        logic       found;
        n = 5'd28;
        found = 1'b0;
        for (int k = 27; k >= 0; k--) begin
            if (x[k] && !found) begin
                n = 5'(27 - k);
                found = 1'b1;
            end
        end
        clz28 = n;
    endfunction

    // Single-precision add with flush-to-zero and RNE. Uses a 28-bit
    // datapath: 24 significand bits plus guard, round, sticky and carry.
    function automatic logic [31:0] fadd(input logic [31:0] a_in, input logic [31:0] b_in);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] t;
        logic [7:0]  d;
        logic [27:0] ma;
        logic [27:0] mb;
        logic [27:0] sh;
        logic        sticky;
        logic [27:0] s;
        logic [4:0]  lz;
        logic signed [10:0] e;
        logic [27:0] n;
        logic        rnd;
        logic [24:0] m;
        logic [31:0] res;
        a = daz(a_in);
        b = daz(b_in);
        if (b[30:0] > a[30:0]) begin
            t = a;
            a = b;
            b = t;
        end
        d = a[30:23] - b[30:23];
        // Bits: [27] carry, [26:3] significand, [2:0] guard/round/sticky.
        ma = {1'b0, 1'b1, a[22:0], 3'd0};
        mb = {1'b0, 1'b1, b[22:0], 3'd0};
        if (d >= 8'd27) begin
            sh = 28'd0;
            sticky = 1'b1;
        end else begin
            sh = mb >> d;
            sticky = ((sh << d) != mb);
        end
        sh[0] = sh[0] | sticky;
        s = (a[31] == b[31]) ? (ma + sh) : (ma - sh);
        lz = clz28(s);
        e = {3'd0, a[30:23]} + 11'sd1;
        // Normalize so the leading one lands in bit 27, keep sticky.
        if (lz == 5'd0) begin
            n = s;
        end else begin
            n = s << lz;
        end
        e = e - 11'(lz);
        rnd = n[3] && ((n[2:0] != 3'd0) || n[4]);
        m = {1'b0, n[27:4]} + {24'd0, rnd};
        if (m[24]) begin
            m = m >> 1;
            e = e + 11'sd1;
        end
        if (e >= 11'sd255) begin
            res = {a[31], 8'hFF, 23'd0};
        end else if (e <= 11'sd0) begin
            res = {a[31], 31'd0};
        end else begin
            res = {a[31], e[7:0], m[22:0]};
        end
        if (is_nan(a) || is_nan(b)) begin
            fadd = QNAN;
        end else if (is_inf(a) && is_inf(b)) begin
            fadd = (a[31] != b[31]) ? QNAN : a;
        end else if (is_inf(a)) begin
            fadd = a;
        end else if (is_inf(b)) begin
            fadd = b;
        end else if (is_zero(a) && is_zero(b)) begin
            fadd = {a[31] & b[31], 31'd0};
        end else if (is_zero(b)) begin
            fadd = a;
        end else if (s == 28'd0) begin
            fadd = POS_ZERO;
        end else begin
            fadd = res;
        end
    endfunction

endpackage

// ===== rtl/core/iq_moment_accumulator_top.sv =====
// Top level of the IQ moment accumulator: product stage, accumulate stage
// and output register. Depends on iqma_pkg.

// Takes one complex sample per clock and returns the five chunk sums
// (I, Q, I*I, Q*Q, I*Q) as single-precision values when a chunk of CHUNK
// samples closes or a sample marked block_end arrives. Throughput is one
// sample per cycle. The result of the sample that closes a chunk goes
// from the input register, which takes the sample at its transfer, to
// the product register, which holds the three rounded products, and
// through the accumulate stage, whose adders are combinational, into
// the output register. Backpressure on the result channel stalls the
// whole pipeline only while a result is waiting.
module iq_moment_accumulator_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  iqma_pkg::iqma_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output iqma_pkg::iqma_out_t  m_data
);
    import iqma_pkg::*;

    logic              in_vld_reg;
    iqma_in_t          in_reg;
    logic              p_vld_reg;
    logic [31:0]       p_i_reg, p_q_reg, p_ii_reg, p_qq_reg, p_iq_reg;
    logic              p_last_reg;
    logic [31:0]       acc_i_reg, acc_q_reg, acc_ii_reg, acc_qq_reg, acc_iq_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              out_vld_reg;
    iqma_out_t         out_reg;

    logic              advance;
    logic [31:0]       acc_i_next, acc_q_next, acc_ii_next, acc_qq_next, acc_iq_next;
    logic [CNT_W-1:0]  cnt_next;
    logic              close_chunk;

    // The pipeline moves unless a result waits at the output.
    assign advance = !out_vld_reg || m_ready;
    assign s_ready = advance;

    // Accumulate stage logic.
    always_comb begin
        acc_i_next  = fadd(acc_i_reg, p_i_reg);
        acc_q_next  = fadd(acc_q_reg, p_q_reg);
        acc_ii_next = fadd(acc_ii_reg, p_ii_reg);
        acc_qq_next = fadd(acc_qq_reg, p_qq_reg);
        acc_iq_next = fadd(acc_iq_reg, p_iq_reg);
        cnt_next    = cnt_reg + CNT_W'(1);
        close_chunk = (cnt_next >= CNT_W'(CHUNK)) || p_last_reg;
    end

    // Pipeline registers and accumulators.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            p_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            acc_i_reg   <= POS_ZERO;
            acc_q_reg   <= POS_ZERO;
            acc_ii_reg  <= POS_ZERO;
            acc_qq_reg  <= POS_ZERO;
            acc_iq_reg  <= POS_ZERO;
            cnt_reg     <= '0;
        end else if (advance) begin
            in_vld_reg <= s_valid;
            in_reg     <= s_data;
            p_vld_reg  <= in_vld_reg;
            p_i_reg    <= in_reg.sample_i;
            p_q_reg    <= in_reg.sample_q;
            p_ii_reg   <= fmul(in_reg.sample_i, in_reg.sample_i);
            p_qq_reg   <= fmul(in_reg.sample_q, in_reg.sample_q);
            p_iq_reg   <= fmul(in_reg.sample_i, in_reg.sample_q);
            p_last_reg <= in_reg.block_end;
            out_vld_reg <= p_vld_reg && close_chunk;
            if (p_vld_reg) begin
                out_reg.sum_i      <= acc_i_next;
                out_reg.sum_q      <= acc_q_next;
                out_reg.sum_ii     <= acc_ii_next;
                out_reg.sum_qq     <= acc_qq_next;
                out_reg.sum_iq     <= acc_iq_next;
                out_reg.chunk_last <= p_last_reg;
                if (close_chunk) begin
                    acc_i_reg  <= POS_ZERO;
                    acc_q_reg  <= POS_ZERO;
                    acc_ii_reg <= POS_ZERO;
                    acc_qq_reg <= POS_ZERO;
                    acc_iq_reg <= POS_ZERO;
                    cnt_reg    <= '0;
                end else begin
                    acc_i_reg  <= acc_i_next;
                    acc_q_reg  <= acc_q_next;
                    acc_ii_reg <= acc_ii_next;
                    acc_qq_reg <= acc_qq_next;
                    acc_iq_reg <= acc_iq_next;
                    cnt_reg    <= cnt_next;
                end
            end
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    // The sample count never reaches a full chunk between results.
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg < CNT_W'(CHUNK))
        else $error("chunk count out of range");

    // A waiting result stalls the input side.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while result stalled");

    // A result is produced only from a valid accumulate stage.
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !p_vld_reg) |=> !m_valid)
        else $error("result without a sample");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for iq_moment_accumulator_top: drives complex samples
// and checks the chunk sums against a behavioral float model. Depends on iqma_pkg.
`timescale 1ns / 1ps

module tb;
    import iqma_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 900;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    iqma_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    iqma_out_t m_data;

    // Model state: five running sums and the sample count of the open chunk.
    logic [31:0] run_i, run_q, run_ii, run_qq, run_iq;
    int          chunk_count;
    iqma_out_t   pending_sums[$];

    int errors;
    int burst_left;
    int idle_cycles;

    iq_moment_accumulator_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Round a nonzero significand worth sig * 2^(e - 190) to single precision.
    function automatic logic [31:0] fp_round(input logic s, input int e_in,
                                             input logic [63:0] sig_in);
        logic [63:0] sig;
        logic [63:0] m;
        logic [63:0] rem;
        int          e;
        sig = sig_in;
        e = e_in;
        while (!sig[63]) begin
            sig = sig << 1;
            e--;
        end
        m = sig >> 40;
        rem = sig & 64'hFF_FFFF_FFFF;
        if (rem > 64'h80_0000_0000 || (rem == 64'h80_0000_0000 && m[0])) m++;
        if (m == 64'h100_0000) begin
            m = m >> 1;
            e++;
        end
        if (e >= 255) return {s, 8'hFF, 23'd0};
        if (e <= 0) return {s, 31'd0};
        return {s, e[7:0], m[22:0]};
    endfunction

    function automatic logic [31:0] flush_denorm(input logic [31:0] x);
        return (x[30:23] == 8'd0) ? {x[31], 31'd0} : x;
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a_in, input logic [31:0] b_in);
        logic [31:0] a;
        logic [31:0] b;
        logic        s;
        logic [63:0] ma;
        logic [63:0] mb;
        a = flush_denorm(a_in);
        b = flush_denorm(b_in);
        if (a[30:0] > 31'h7F80_0000 || b[30:0] > 31'h7F80_0000) return QNAN;
        s = a[31] ^ b[31];
        if (a[30:0] == 31'h7F80_0000 || b[30:0] == 31'h7F80_0000) begin
            if (a[30:0] == 0 || b[30:0] == 0) return QNAN;
            return {s, 8'hFF, 23'd0};
        end
        if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
        ma = {40'd0, 1'b1, a[22:0]};
        mb = {40'd0, 1'b1, b[22:0]};
        return fp_round(s, int'(a[30:23]) + int'(b[30:23]) - 110, ma * mb);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a_in, input logic [31:0] b_in);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] t;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] lost;
        logic [63:0] sum;
        int          d;
        a = flush_denorm(a_in);
        b = flush_denorm(b_in);
        if (a[30:0] > 31'h7F80_0000 || b[30:0] > 31'h7F80_0000) return QNAN;
        if (a[30:0] == 31'h7F80_0000 && b[30:0] == 31'h7F80_0000)
            return (a[31] != b[31]) ? QNAN : a;
        if (a[30:0] == 31'h7F80_0000) return a;
        if (b[30:0] == 31'h7F80_0000) return b;
        if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
        if (a[30:0] == 0) return b;
        if (b[30:0] == 0) return a;
        if (b[30:0] > a[30:0]) begin
            t = a;
            a = b;
            b = t;
        end
        ma = {40'd0, 1'b1, a[22:0]} << 39;
        mb = {40'd0, 1'b1, b[22:0]} << 39;
        d = int'(a[30:23]) - int'(b[30:23]);
        if (d >= 63) begin
            mb = 64'd1;
        end else if (d > 0) begin
            lost = mb & ((64'd1 << d) - 64'd1);
            mb = (mb >> d) | ((lost != 0) ? 64'd1 : 64'd0);
        end
        if (a[31] == b[31]) begin
            sum = ma + mb;
        end else begin
            sum = ma - mb;
            if (sum == 0) return POS_ZERO;
        end
        return fp_round(a[31], int'(a[30:23]) + 1, sum);
    endfunction

    // Fold one accepted sample into the sums; queue the result when a chunk closes.
    task automatic predict_moments(input iqma_in_t x);
        iqma_out_t r;
        run_i = fp_add(run_i, x.sample_i);
        run_q = fp_add(run_q, x.sample_q);
        run_ii = fp_add(run_ii, fp_mul(x.sample_i, x.sample_i));
        run_qq = fp_add(run_qq, fp_mul(x.sample_q, x.sample_q));
        run_iq = fp_add(run_iq, fp_mul(x.sample_i, x.sample_q));
        chunk_count++;
        if (chunk_count >= CHUNK || x.block_end) begin
            r.sum_i = run_i;
            r.sum_q = run_q;
            r.sum_ii = run_ii;
            r.sum_qq = run_qq;
            r.sum_iq = run_iq;
            r.chunk_last = x.block_end;
            pending_sums.push_back(r);
            run_i = POS_ZERO;
            run_q = POS_ZERO;
            run_ii = POS_ZERO;
            run_qq = POS_ZERO;
            run_iq = POS_ZERO;
            chunk_count = 0;
        end
    endtask

    // Send one sample; the sender works in bursts with random gaps between them.
    task automatic send_sample(input logic [31:0] i_bits, input logic [31:0] q_bits,
                               input logic last);
        iqma_in_t x;
        logic     taken;
        int       gap;
        x.sample_i = i_bits;
        x.sample_q = q_bits;
        x.block_end = last;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= x;
        do begin
            @(negedge aclk);
            taken = s_ready;
            if (taken) predict_moments(x);
            @(posedge aclk);
        end while (!taken);
    endtask

    // Random sample value: mostly moderate normals, some large normals, specials, denormals and raw bits.
    function automatic logic [31:0] random_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 19))
            0: ;
            1: v[30:23] = 8'hFF;
            2: v[30:23] = 8'h00;
            3: v[30:0] = 31'd0;
            4: v[30:23] = 8'($urandom_range(230, 254));
            default: v[30:23] = 8'($urandom_range(100, 154));
        endcase
        return v;
    endfunction

    task automatic wait_for_results();
        while (pending_sums.size() != 0) @(posedge aclk);
    endtask

    // Extremes of the fields and the special values, sent in short blocks.
    task automatic test_special_values();
        send_sample(32'h0000_0000, 32'h8000_0000, 1'b1);
        send_sample(32'h8000_0000, 32'h8000_0000, 1'b1);
        send_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_sample(32'h7F80_0000, 32'h0000_0000, 1'b1);
        send_sample(32'h7F80_0000, 32'h3F80_0000, 1'b0);
        send_sample(32'hFF80_0000, 32'h3F80_0000, 1'b1);
        send_sample(32'h007F_FFFF, 32'h8000_0001, 1'b1);
        send_sample(32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b0);
        send_sample(32'h7F7F_FFFF, 32'hFF7F_FFFF, 1'b1);
        send_sample(32'h3F80_0000, 32'hBF80_0000, 1'b0);
        send_sample(32'hBF80_0000, 32'h3F80_0000, 1'b1);
        send_sample(32'h0080_0000, 32'h0080_0000, 1'b0);
        send_sample(32'h1FFF_FFFF, 32'h2000_0001, 1'b1);
        send_sample(32'h4B80_0000, 32'h3380_0000, 1'b0);
        send_sample(32'h3380_0001, 32'hCB80_0000, 1'b1);
        send_sample(32'h7FC0_0000, 32'h0123_4567, 1'b1);
        send_sample(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        send_sample(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    endtask

    // A chunk closed by size, then a full chunk that also ends its block.
    task automatic test_full_chunks();
        for (int k = 0; k < CHUNK; k++)
            send_sample(random_float(), random_float(), 1'b0);
        for (int k = 0; k < CHUNK; k++)
            send_sample(random_float(), random_float(), k == CHUNK - 1);
    endtask

    // The sender holds off until every queued result has been checked.
    task automatic test_drain_pause();
        send_sample(32'h4000_0000, 32'hC000_0000, 1'b1);
        s_valid <= 1'b0;
        wait_for_results();
        send_sample(32'h4040_0000, 32'h4040_0000, 1'b1);
    endtask

    // Blocks of random length, mostly short, now and then past a chunk.
    task automatic test_random_blocks();
        int sent;
        int len;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: len = CHUNK + $urandom_range(0, 40);
                1: len = CHUNK;
                default: len = $urandom_range(1, 60);
            endcase
            for (int k = 0; k < len; k++)
                send_sample(random_float(), random_float(), k == len - 1);
            sent += len;
        end
    endtask

    // Receiver stall pattern: runs of always ready, random ready, and stalled.
    int rx_run;
    int rx_mode;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_run <= 0;
            rx_mode <= 0;
        end else begin
            if (rx_run == 0) begin
                rx_mode <= $urandom_range(0, 2);
                rx_run <= $urandom_range(1, 30);
                m_ready <= 1'b1;
            end else begin
                rx_run <= rx_run - 1;
                case (rx_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= 1'b0;
                endcase
            end
        end
    end

    // Check each result transfer against the oldest expected sums.
    always @(negedge aclk) begin
        iqma_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_sums.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", m_data);
            end else begin
                want = pending_sums.pop_front();
                if (m_data.sum_i != want.sum_i || m_data.sum_q != want.sum_q ||
                    m_data.sum_ii != want.sum_ii || m_data.sum_qq != want.sum_qq ||
                    m_data.sum_iq != want.sum_iq || m_data.chunk_last != want.chunk_last) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %h %h %h %h %h %b got %h %h %h %h %h %b",
                                 want.sum_i, want.sum_q, want.sum_ii, want.sum_qq,
                                 want.sum_iq, want.chunk_last, m_data.sum_i, m_data.sum_q,
                                 m_data.sum_ii, m_data.sum_qq, m_data.sum_iq,
                                 m_data.chunk_last);
                end
            end
        end
    end

    // Watchdog: too many cycles without any transfer ends the run.
    always @(negedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles > IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        errors = 0;
        burst_left = 0;
        idle_cycles = 0;
        run_i = POS_ZERO;
        run_q = POS_ZERO;
        run_ii = POS_ZERO;
        run_qq = POS_ZERO;
        run_iq = POS_ZERO;
        chunk_count = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_special_values();
        test_full_chunks();
        test_drain_pause();
        test_random_blocks();

        s_valid <= 1'b0;
        wait_for_results();
        repeat (10) @(posedge aclk);
        if (pending_sums.size() != 0) errors++;
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
